### hdl/cli_pkg.sv
// Package for the clamped linear interpolator: widths, request/result structs.
// No dependencies; imported by the top level, the checker and the testbench.
package cli_pkg;

  localparam int DATA_W         = 32;
  localparam int ENTRY_IDX_W    = 4;
  localparam int POINT_CNT_W    = 5;
  localparam int MAX_POINTS_DEF = 16;
  localparam int STEP_CNT_W     = $clog2(DATA_W);

  localparam logic MODE_LOAD  = 1'b0;
  localparam logic MODE_QUERY = 1'b1;

  typedef struct packed {
    logic                     mode;
    logic [ENTRY_IDX_W-1:0]   entry_index;
    logic signed [DATA_W-1:0] x_value;
    logic signed [DATA_W-1:0] y_value;
  } cli_req_t;

  typedef struct packed {
    logic signed [DATA_W-1:0] y_result;
    logic                     clamped;
  } cli_res_t;

endpackage

### hdl/clamped_linear_interpolator.sv
// Top level of the clamped piecewise linear interpolator (signed Q16.16).
// Depends on cli_pkg and cli_ram.
//
// A load request writes one breakpoint when it is accepted; busy stays low. A
// query reads the table one entry per cycle from its single read port: first
// entry, last entry in use, then a linear scan from entry 1. A clamped answer
// comes from state S_LAST (first entry) or S_CHKL (last entry). An answer
// that is interpolated passes the scan, S_SETUP, S_ABS, S_MUL, S_DIV and S_FIN;
// the scan stops at the upper breakpoint, entry 1 up to the last entry in use.
// The product and the quotient are each formed one bit per cycle by a 34-bit
// shift-add/subtract unit. The result is shown for one cycle with res_strobe_o
// and cannot be held off; busy falls in that same cycle.
// The table reads as zero after reset through per-entry valid flags.
module clamped_linear_interpolator
  import cli_pkg::*;
#(
  parameter int MAX_POINTS = MAX_POINTS_DEF
) (
  input  logic                   clk_i,
  input  logic                   rst_ni,
  input  logic                   start,
  output logic                   busy,
  input  cli_req_t               req_i,
  output logic                   res_strobe_o,
  output cli_res_t               res_o,
  input  logic                   cfg_valid_i,
  output logic                   cfg_ready_o,
  input  logic [POINT_CNT_W-1:0] cfg_data_i
);

  localparam int IDX_W = $clog2(MAX_POINTS);

  typedef enum logic [9:0] {
    S_IDLE  = 10'b0000000001,
    S_FIRST = 10'b0000000010,
    S_LAST  = 10'b0000000100,
    S_CHKL  = 10'b0000001000,
    S_SCAN  = 10'b0000010000,
    S_SETUP = 10'b0000100000,
    S_ABS   = 10'b0001000000,
    S_MUL   = 10'b0010000000,
    S_DIV   = 10'b0100000000,
    S_FIN   = 10'b1000000000
  } state_e;

  state_e                   state_q, state_d;
  logic [POINT_CNT_W-1:0]   point_count_q;
  logic [MAX_POINTS-1:0]    vld_q;
  logic                     rd_vld_q;
  logic [IDX_W-1:0]         k_q, k_d;
  logic [STEP_CNT_W-1:0]    step_q, step_d;
  logic signed [DATA_W-1:0] xq_q, xq_d;
  logic signed [DATA_W-1:0] x0_q, x0_d, y0_q, y0_d, x1_q, x1_d, y1_q, y1_d;
  logic [DATA_W:0]          span_q, span_d;
  logic [DATA_W:0]          dy_q, dy_d;
  logic                     neg_q, neg_d;
  logic [DATA_W+1:0]        hi_q, hi_d;
  logic [DATA_W-1:0]        lo_q, lo_d;
  cli_res_t                 res_q, res_d;
  logic                     strobe_q, strobe_d;

  logic                     accept;
  logic                     wr_en;
  logic [IDX_W-1:0]         wr_addr;
  logic [IDX_W-1:0]         rd_addr;
  logic [IDX_W-1:0]         last_idx;
  logic [2*DATA_W-1:0]      rd_data;
  logic signed [DATA_W-1:0] ent_x, ent_y;
  logic                     rd_vld_d;
  logic [DATA_W+1:0]        mul_sum;
  logic [DATA_W+1:0]        div_t;
  logic                     div_ge;

  assign accept      = start && !busy;
  assign busy        = (state_q != S_IDLE);
  assign cfg_ready_o = 1'b1;
  assign res_o        = res_q;
  assign res_strobe_o = strobe_q;

  assign wr_addr = IDX_W'(req_i.entry_index);
  assign wr_en   = accept && (req_i.mode == MODE_LOAD) &&
                   (32'(req_i.entry_index) < MAX_POINTS);

  always_comb begin
    if (point_count_q == '0) begin
      last_idx = '0;
    end else if (32'(point_count_q) > MAX_POINTS) begin
      last_idx = IDX_W'(MAX_POINTS - 1);
    end else begin
      last_idx = IDX_W'(point_count_q - POINT_CNT_W'(1));
    end
  end

  always_comb begin
    case (state_q)
      S_FIRST: rd_addr = '0;
      S_LAST:  rd_addr = last_idx;
      S_CHKL:  rd_addr = IDX_W'(1);
      S_SCAN:  rd_addr = k_q + IDX_W'(1);
      default: rd_addr = '0;
    endcase
  end

  assign rd_vld_d = (32'(rd_addr) < MAX_POINTS) ? vld_q[rd_addr] : 1'b0;

  cli_ram #(
    .WIDTH (2 * DATA_W),
    .DEPTH (MAX_POINTS)
  ) u_table (
    .clk_i   (clk_i),
    .we_i    (wr_en),
    .waddr_i (wr_addr),
    .wdata_i ({req_i.x_value, req_i.y_value}),
    .raddr_i (rd_addr),
    .rdata_o (rd_data)
  );

  // never-written entries read as zero
  assign ent_x = rd_vld_q ? $signed(rd_data[2*DATA_W-1:DATA_W]) : '0;
  assign ent_y = rd_vld_q ? $signed(rd_data[DATA_W-1:0]) : '0;

  assign mul_sum = hi_q + (lo_q[0] ? {1'b0, dy_q} : '0);
  assign div_t   = {hi_q[DATA_W:0], lo_q[DATA_W-1]};
  assign div_ge  = (div_t >= {1'b0, span_q});

  always_comb begin
    state_d  = state_q;
    k_d      = k_q;
    step_d   = step_q;
    xq_d     = xq_q;
    x0_d     = x0_q;
    y0_d     = y0_q;
    x1_d     = x1_q;
    y1_d     = y1_q;
    span_d   = span_q;
    dy_d     = dy_q;
    neg_d    = neg_q;
    hi_d     = hi_q;
    lo_d     = lo_q;
    res_d    = res_q;
    strobe_d = 1'b0;
    case (state_q)
      S_IDLE: begin
        if (accept && (req_i.mode == MODE_QUERY)) begin
          xq_d    = req_i.x_value;
          state_d = S_FIRST;
        end
      end
      S_FIRST: begin
        state_d = S_LAST;
      end
      S_LAST: begin
        if (xq_q <= ent_x) begin
          res_d    = '{y_result: ent_y, clamped: 1'b1};
          strobe_d = 1'b1;
          state_d  = S_IDLE;
        end else begin
          x0_d    = ent_x;
          y0_d    = ent_y;
          state_d = S_CHKL;
        end
      end
      S_CHKL: begin
        if (xq_q >= ent_x) begin
          res_d    = '{y_result: ent_y, clamped: 1'b1};
          strobe_d = 1'b1;
          state_d  = S_IDLE;
        end else begin
          k_d     = IDX_W'(1);
          state_d = S_SCAN;
        end
      end
      S_SCAN: begin
        if ((xq_q < ent_x) || (k_q == last_idx)) begin
          x1_d    = ent_x;
          y1_d    = ent_y;
          state_d = S_SETUP;
        end else begin
          x0_d = ent_x;
          y0_d = ent_y;
          k_d  = k_q + IDX_W'(1);
        end
      end
      S_SETUP: begin
        span_d  = {x1_q[DATA_W-1], x1_q} - {x0_q[DATA_W-1], x0_q};
        lo_d    = xq_q - x0_q;
        dy_d    = {y1_q[DATA_W-1], y1_q} - {y0_q[DATA_W-1], y0_q};
        hi_d    = '0;
        state_d = S_ABS;
      end
      S_ABS: begin
        neg_d   = dy_q[DATA_W];
        dy_d    = dy_q[DATA_W] ? (~dy_q + (DATA_W+1)'(1)) : dy_q;
        step_d  = '0;
        state_d = S_MUL;
      end
      S_MUL: begin
        // shift-add, one multiplier bit per cycle
        hi_d   = {1'b0, mul_sum[DATA_W+1:1]};
        lo_d   = {mul_sum[0], lo_q[DATA_W-1:1]};
        step_d = step_q + STEP_CNT_W'(1);
        if (step_q == '1) begin
          state_d = S_DIV;
        end
      end
      S_DIV: begin
        // restoring division; upper half of product is already below span
        hi_d   = div_ge ? (div_t - {1'b0, span_q}) : div_t;
        lo_d   = {lo_q[DATA_W-2:0], div_ge};
        step_d = step_q + STEP_CNT_W'(1);
        if (step_q == '1) begin
          state_d = S_FIN;
        end
      end
      S_FIN: begin
        res_d.y_result = neg_q ? (y0_q - $signed(lo_q)) : (y0_q + $signed(lo_q));
        res_d.clamped  = 1'b0;
        strobe_d       = 1'b1;
        state_d        = S_IDLE;
      end
      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q       <= S_IDLE;
      point_count_q <= POINT_CNT_W'(1);
      vld_q         <= '0;
      strobe_q      <= 1'b0;
      rd_vld_q      <= 1'b0;
    end else begin
      state_q  <= state_d;
      strobe_q <= strobe_d;
      rd_vld_q <= rd_vld_d;
      if (cfg_valid_i && cfg_ready_o) begin
        point_count_q <= cfg_data_i;
      end
      if (wr_en) begin
        vld_q[wr_addr] <= 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    k_q    <= k_d;
    step_q <= step_d;
    xq_q   <= xq_d;
    x0_q   <= x0_d;
    y0_q   <= y0_d;
    x1_q   <= x1_d;
    y1_q   <= y1_d;
    span_q <= span_d;
    dy_q   <= dy_d;
    neg_q  <= neg_d;
    hi_q   <= hi_d;
    lo_q   <= lo_d;
    res_q  <= res_d;
  end

  a_strobe_source: assert property (@(posedge clk_i) disable iff (!rst_ni)
    strobe_q |-> ($past(state_q) == S_LAST) || ($past(state_q) == S_CHKL) ||
                 ($past(state_q) == S_FIN))
    else $error("result strobe without a finishing step");

  a_strobe_idle: assert property (@(posedge clk_i) disable iff (!rst_ni)
    strobe_q |-> (state_q == S_IDLE))
    else $error("result strobe while a request is still in progress");

  a_offset_in_span: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == S_ABS) |-> (span_q != '0) && ({1'b0, lo_q} < span_q))
    else $error("query offset not inside the breakpoint span");

  a_rem_below_span: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == S_DIV) |-> (hi_q < {1'b0, span_q}))
    else $error("division remainder not below the span");

  a_quot_in_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == S_FIN) |-> ({1'b0, lo_q} <= dy_q))
    else $error("quotient exceeds the y step");

endmodule

### hdl/cli_ram.sv
// Generic single-write, single-read RAM with registered read data.
// Depends on nothing; used for the breakpoint table.
module cli_ram #(
  parameter int WIDTH = 64,
  parameter int DEPTH = 16
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(DEPTH)-1:0] waddr_i,
  input  logic [WIDTH-1:0]         wdata_i,
  input  logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rdata_o <= mem_q[raddr_i];
  end

endmodule

### test/cli_checker.sv
// Checker for the clamped linear interpolator: watches request, result and config channels.
// Keeps its own table and point count, predicts each query answer and compares in order.
// Depends on cli_pkg.
`timescale 1ns / 100ps

module cli_checker
  import cli_pkg::*;
(
  input  logic                   clk_i,
  input  logic                   rst_ni,
  input  logic                   start_i,
  input  logic                   busy_i,
  input  cli_req_t               req_i,
  input  logic                   res_strobe_i,
  input  cli_res_t               res_i,
  input  logic                   cfg_valid_i,
  input  logic                   cfg_ready_i,
  input  logic [POINT_CNT_W-1:0] cfg_data_i,
  output int                     mismatch_count_o,
  output int                     answers_pending_o
);

  localparam int TABLE_DEPTH = MAX_POINTS_DEF;

  logic signed [DATA_W-1:0] knot_x [TABLE_DEPTH];
  logic signed [DATA_W-1:0] knot_y [TABLE_DEPTH];
  logic [POINT_CNT_W-1:0]   knot_count;
  cli_res_t                 pending_answers[$];

  function automatic cli_res_t interpolate_y(input logic signed [DATA_W-1:0] xq);
    cli_res_t           ans;
    int                 n;
    int                 k;
    logic signed [63:0] x0, x1, y0, y1, dy, sum;
    logic [63:0]        span, off, mag, quot;
    n = (knot_count == 0) ? 1 : (knot_count > TABLE_DEPTH) ? TABLE_DEPTH : int'(knot_count);
    ans.clamped = 1'b1;
    if (xq <= knot_x[0]) begin
      ans.y_result = knot_y[0];
      return ans;
    end
    if (xq >= knot_x[n-1]) begin
      ans.y_result = knot_y[n-1];
      return ans;
    end
    k = 1;
    while (k < n - 1 && xq >= knot_x[k]) k++;
    x0   = knot_x[k-1];
    x1   = knot_x[k];
    y0   = knot_y[k-1];
    y1   = knot_y[k];
    span = x1 - x0;
    off  = (64'(signed'(xq))) - x0;
    dy   = y1 - y0;
    mag  = (dy < 0) ? -dy : dy;
    quot = (mag * off) / span;
    sum  = (dy < 0) ? y0 - signed'(quot) : y0 + signed'(quot);
    ans.y_result = sum[DATA_W-1:0];
    ans.clamped  = 1'b0;
    return ans;
  endfunction

  always @(posedge clk_i or negedge rst_ni) begin
    cli_res_t want;
    if (!rst_ni) begin
      for (int i = 0; i < TABLE_DEPTH; i++) begin
        knot_x[i] = '0;
        knot_y[i] = '0;
      end
      knot_count = 1;
      pending_answers.delete();
      mismatch_count_o  = 0;
      answers_pending_o = 0;
    end else begin
      if (res_strobe_i) begin
        if (pending_answers.size() == 0) begin
          $display("%0t: unexpected result y_result %0d clamped %0b", $time,
                   res_i.y_result, res_i.clamped);
          mismatch_count_o++;
        end else begin
          want = pending_answers.pop_front();
          if (res_i.y_result !== want.y_result) begin
            $display("%0t: y_result expected %0d got %0d", $time,
                     want.y_result, res_i.y_result);
            mismatch_count_o++;
          end
          if (res_i.clamped !== want.clamped) begin
            $display("%0t: clamped expected %0b got %0b", $time,
                     want.clamped, res_i.clamped);
            mismatch_count_o++;
          end
        end
      end
      if (cfg_valid_i && cfg_ready_i) knot_count = cfg_data_i;
      if (start_i && !busy_i) begin
        if (req_i.mode == MODE_LOAD) begin
          if (req_i.entry_index < TABLE_DEPTH) begin
            knot_x[req_i.entry_index] = req_i.x_value;
            knot_y[req_i.entry_index] = req_i.y_value;
          end
        end else begin
          pending_answers.insert(pending_answers.size(), interpolate_y(req_i.x_value));
        end
      end
      answers_pending_o = pending_answers.size();
    end
  end

endmodule

### test/tb_clamped_linear_interpolator.sv
// Testbench top for clamped_linear_interpolator: clock, reset, request and config stimulus.
// Answers are checked by cli_checker; this module gives the verdict. Depends on cli_pkg.
`timescale 1ns / 100ps

module tb_clamped_linear_interpolator;
  import cli_pkg::*;

  localparam int                       ITEM_TARGET   = 1000;
  localparam int                       SETTLE_CYCLES = 100;
  localparam int                       IDLE_LIMIT    = 3000;
  localparam logic signed [DATA_W-1:0] Q_MIN         = 32'sh8000_0000;
  localparam logic signed [DATA_W-1:0] Q_MAX         = 32'sh7fff_ffff;

  logic                   clk;
  logic                   rst_n;
  logic                   start;
  logic                   busy;
  cli_req_t               req;
  logic                   res_strobe;
  cli_res_t               res;
  logic                   cfg_valid;
  logic                   cfg_ready;
  logic [POINT_CNT_W-1:0] cfg_data;
  int                     mismatch_count;
  int                     answers_pending;

  logic signed [DATA_W-1:0] tab_x [MAX_POINTS_DEF];
  int                       n_used;
  int                       items_sent;
  int                       burst_left;
  int                       idle_cycles;

  clamped_linear_interpolator uut (
    .clk_i       (clk),
    .rst_ni      (rst_n),
    .start       (start),
    .busy        (busy),
    .req_i       (req),
    .res_strobe_o(res_strobe),
    .res_o       (res),
    .cfg_valid_i (cfg_valid),
    .cfg_ready_o (cfg_ready),
    .cfg_data_i  (cfg_data)
  );

  cli_checker u_checker (
    .clk_i            (clk),
    .rst_ni           (rst_n),
    .start_i          (start),
    .busy_i           (busy),
    .req_i            (req),
    .res_strobe_i     (res_strobe),
    .res_i            (res),
    .cfg_valid_i      (cfg_valid),
    .cfg_ready_i      (cfg_ready),
    .cfg_data_i       (cfg_data),
    .mismatch_count_o (mismatch_count),
    .answers_pending_o(answers_pending)
  );

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  always @(posedge clk) begin
    if (!rst_n) begin
      idle_cycles <= 0;
    end else begin
      if ((start && !busy) || res_strobe || (cfg_valid && cfg_ready)) begin
        idle_cycles <= 0;
      end else begin
        idle_cycles <= idle_cycles + 1;
      end
      if (idle_cycles >= IDLE_LIMIT) begin
        $display("Regression FAIL");
        $finish;
      end
    end
  end

  task automatic send(input cli_req_t r);
    int gap;
    if (burst_left == 0) begin
      burst_left = $urandom_range(1, 24);
      gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 60);
      if (gap != 0) begin
        start <= 1'b0;
        repeat (gap) @(posedge clk);
      end
    end
    burst_left--;
    start <= 1'b1;
    req   <= r;
    do @(posedge clk); while (busy);
    items_sent++;
  endtask

  task automatic load_entry(input int idx, input logic signed [DATA_W-1:0] x,
                            input logic signed [DATA_W-1:0] y);
    cli_req_t r;
    r.mode        = MODE_LOAD;
    r.entry_index = idx[ENTRY_IDX_W-1:0];
    r.x_value     = x;
    r.y_value     = y;
    tab_x[idx]    = x;
    send(r);
  endtask

  task automatic query(input logic signed [DATA_W-1:0] x);
    cli_req_t r;
    r.mode        = MODE_QUERY;
    r.entry_index = ENTRY_IDX_W'($urandom);
    r.x_value     = x;
    r.y_value     = $urandom;
    send(r);
  endtask

  // wait for every answer, then let any load or query in flight settle
  task automatic drain();
    start      <= 1'b0;
    burst_left = 0;
    do @(posedge clk); while (answers_pending != 0);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  task automatic write_count(input int v);
    drain();
    cfg_valid <= 1'b1;
    cfg_data  <= POINT_CNT_W'(v);
    do @(posedge clk); while (!cfg_ready);
    cfg_valid <= 1'b0;
    n_used = (v == 0) ? 1 : (v > MAX_POINTS_DEF) ? MAX_POINTS_DEF : v;
  endtask

  function automatic logic signed [DATA_W-1:0] random_y();
    if ($urandom_range(0, 1) == 0) return $urandom;
    return DATA_W'($urandom_range(0, 32'd26214400)) - DATA_W'(32'd13107200);
  endfunction

  task automatic fill_table();
    int                 style;
    int unsigned        step_max;
    logic signed [63:0] acc;
    style = $urandom_range(0, 5);
    case (style)
      0, 1: begin
        acc      = ($urandom_range(0, 3) == 0) ? 64'(Q_MIN) :
                   64'(Q_MIN) + $urandom_range(0, 32'h2000_0000);
        step_max = 32'h1000_0000;
      end
      2, 3: begin
        acc      = -64'($urandom_range(0, 32'd13107200));
        step_max = 32'd2621440;
      end
      default: begin
        acc      = 64'(signed'(DATA_W'($urandom)));
        step_max = 4;
      end
    endcase
    for (int i = 0; i < MAX_POINTS_DEF; i++) begin
      if (style == 5) begin
        load_entry(i, $urandom, random_y());
      end else begin
        load_entry(i, acc[DATA_W-1:0], random_y());
        if ($urandom_range(0, 15) != 0) acc = acc + $urandom_range(1, step_max);
        if (acc > 64'(Q_MAX)) acc = 64'(Q_MAX);
      end
    end
  endtask

  task automatic random_query();
    logic signed [63:0] lo, hi, q;
    logic [63:0]        r64;
    lo  = tab_x[0];
    hi  = tab_x[n_used-1];
    r64 = {$urandom, $urandom};
    case ($urandom_range(0, 7))
      0: q = tab_x[$urandom_range(0, n_used - 1)];
      1: q = tab_x[$urandom_range(0, n_used - 1)] + (($urandom_range(0, 1) == 0) ? 1 : -1);
      2, 3, 4: begin
        if (hi > lo) q = lo + signed'(r64 % 64'(hi - lo + 1));
        else q = 64'(signed'(DATA_W'($urandom)));
      end
      5: q = ($urandom_range(0, 1) == 0) ? 64'(Q_MIN) : 64'(Q_MAX);
      default: q = 64'(signed'(DATA_W'($urandom)));
    endcase
    query(q[DATA_W-1:0]);
  endtask

  initial begin
    int  cnt;
    bit  first_phase;
    rst_n       = 1'b0;
    start       = 1'b0;
    req         = '0;
    cfg_valid   = 1'b0;
    cfg_data    = '0;
    items_sent  = 0;
    burst_left  = 0;
    n_used      = 1;
    first_phase = 1'b1;
    for (int i = 0; i < MAX_POINTS_DEF; i++) tab_x[i] = '0;
    repeat (7) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // cleared table, one point
    query(0);
    query(Q_MIN);
    query(Q_MAX);
    load_entry(0, Q_MIN, Q_MAX);
    load_entry(1, Q_MAX, Q_MIN);
    query(0);
    // count of zero acts as one
    write_count(0);
    query(Q_MIN);
    // two points spanning the whole range, falling then flat then rising
    write_count(2);
    query(Q_MIN);
    query(Q_MAX);
    query(0);
    query(Q_MIN + 1);
    query(Q_MAX - 1);
    load_entry(1, Q_MAX, Q_MAX);
    query(0);
    load_entry(0, Q_MIN, Q_MIN);
    query(-1);
    // oversized count over a table that is no longer ascending
    write_count(31);
    query(5);
    query(-5);
    write_count(17);
    query(-5);
    load_entry(15, 32'sd6553600, 32'sd458752);
    write_count(16);
    query(32'sd6488064);

    while (items_sent < ITEM_TARGET) begin
      case ($urandom_range(0, 9))
        0: cnt = 0;
        1: cnt = 1;
        2: cnt = 2;
        3: cnt = 16;
        4: cnt = 17;
        5: cnt = 31;
        default: cnt = $urandom_range(2, 16);
      endcase
      write_count(cnt);
      if (first_phase || $urandom_range(0, 3) != 0) fill_table();
      first_phase = 1'b0;
      repeat ($urandom_range(15, 50)) begin
        if ($urandom_range(0, 19) == 0) begin
          load_entry($urandom_range(0, MAX_POINTS_DEF - 1), $urandom, random_y());
        end else begin
          random_query();
        end
      end
    end

    drain();
    if (mismatch_count == 0) begin
      $display("Regression PASS");
    end else begin
      $display("Regression FAIL");
    end
    $finish;
  end

endmodule

### clamped_linear_interpolator.f
hdl/cli_pkg.sv
hdl/cli_ram.sv
hdl/clamped_linear_interpolator.sv
test/cli_checker.sv
test/tb_clamped_linear_interpolator.sv
